@@ hdl/adcbgp_pkg.sv @@
`timescale 1ns / 1ps

package adcbgp_pkg;

    localparam int RawW   = 32;
    localparam int PcmW   = 16;
    localparam int GainW  = 4;
    localparam int PoleW  = 15;
    localparam int CfgIdxW = 8;

    localparam logic [GainW-1:0] GainReset = 4'd6;
    localparam logic [PoleW-1:0] PoleReset = 15'd32604;

    localparam logic [CfgIdxW-1:0] CFG_GAIN_FACTOR = 8'd0;
    localparam logic [CfgIdxW-1:0] CFG_POLE_COEFF  = 8'd1;

    localparam logic signed [PcmW-1:0] PcmMax = 16'sh7fff;
    localparam logic signed [PcmW-1:0] PcmMin = 16'sh8000;

    typedef struct packed {
        logic signed [RawW-1:0] raw_word;
        logic                   last_in_block;
    } in_item_t;

    typedef struct packed {
        logic signed [PcmW-1:0] pcm_sample;
        logic [PcmW-1:0]        block_peak;
        logic                   block_end;
    } out_item_t;

    // handshake between the sequencer and a serial multiplier
    typedef struct packed {
        logic start;
    } mul_req_t;

    typedef struct packed {
        logic done;
    } mul_rsp_t;

endpackage

@@ hdl/adcbgp_pole_mul.sv @@
`timescale 1ns / 1ps

module adcbgp_pole_mul
    import adcbgp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mul_req_t                req,
    input  logic signed [RawW-1:0]  y,
    input  logic [PoleW-1:0]        pole,
    output mul_rsp_t                rsp,
    output logic [RawW-1:0]         fb
);

    localparam int CntW = $clog2(PoleW);
    localparam logic [CntW-1:0] LastBit = CntW'(PoleW - 1);

    logic signed [RawW:0]  acc_reg, acc_next;
    logic [PoleW-1:0]      coef_reg, coef_next;
    logic [CntW-1:0]       cnt_reg, cnt_next;
    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic signed [RawW:0]  addend;
    logic signed [RawW:0]  part;

    // LSB-first shift-add; the right shift each step drops exactly the
    // low product bits, so after PoleW steps acc = floor(y * pole / 2^15)
    always_comb
    begin
        addend    = coef_reg[0] ? {y[RawW-1], y} : '0;
        part      = acc_reg + addend;
        acc_next  = acc_reg;
        coef_next = coef_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (req.start)
        begin
            acc_next  = '0;
            coef_next = pole;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = part >>> 1;
            coef_next = coef_reg >> 1;
            cnt_next  = cnt_reg + 1'b1;
            if (cnt_reg == LastBit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        coef_reg <= coef_next;
    end

    assign rsp.done = done_reg;
    assign fb       = acc_reg[RawW-1:0];

endmodule

@@ hdl/adcbgp_gain_sat.sv @@
`timescale 1ns / 1ps

module adcbgp_gain_sat
    import adcbgp_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  mul_req_t                req,
    input  logic signed [RawW-1:0]  sum,
    input  logic [GainW-1:0]        gain,
    output mul_rsp_t                rsp,
    output logic signed [PcmW-1:0]  pcm,
    output logic [PcmW-1:0]         mag
);

    localparam int AccW = RawW + GainW;
    localparam int CntW = $clog2(GainW);
    localparam logic [CntW-1:0] LastBit = CntW'(GainW - 1);

    logic signed [AccW-1:0] acc_reg, acc_next;
    logic signed [RawW-1:0] mcand_reg, mcand_next;
    logic [GainW-1:0]       g_reg, g_next;
    logic [CntW-1:0]        cnt_reg, cnt_next;
    logic                   busy_reg, busy_next;
    logic                   done_reg, done_next;
    logic signed [AccW-1:0] addend;

    // MSB-first over the gain bits
    always_comb
    begin
        addend     = g_reg[GainW-1] ? AccW'(mcand_reg) : '0;
        acc_next   = acc_reg;
        mcand_next = mcand_reg;
        g_next     = g_reg;
        cnt_next   = cnt_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (req.start)
        begin
            acc_next   = '0;
            mcand_next = sum;
            g_next     = gain;
            cnt_next   = '0;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = (acc_reg <<< 1) + addend;
            g_next   = g_reg << 1;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LastBit)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg  <= '0;
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            cnt_reg  <= cnt_next;
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg   <= acc_next;
        mcand_reg <= mcand_next;
        g_reg     <= g_next;
    end

    always_comb
    begin
        if (acc_reg > AccW'(PcmMax))
            pcm = PcmMax;
        else if (acc_reg < AccW'(PcmMin))
            pcm = PcmMin;
        else
            pcm = acc_reg[PcmW-1:0];
        // -32768 maps to 0x8000 as unsigned
        mag = pcm[PcmW-1] ? (~pcm + 1'b1) : pcm;
    end

    assign rsp.done = done_reg;

endmodule

@@ hdl/audio_dc_block_gain_peak_unit.sv @@
`timescale 1ns / 1ps
// DC-blocking high-pass, integer gain with int16 saturation, block peak meter.
// Input channel (in_valid/in_ready, in_data): one left-channel I2S word per
// request; bits 31:16 form the sample. last_in_block closes a peak block.
// Output channel (out_valid/out_ready, out_data): one result per request with
// the saturated sample; on a block's last request it also carries the block
// peak (0..32768) with block_end set, and the peak restarts from zero.
// Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data): index 0 gain,
// index 1 pole coefficient (Q15). Always ready; write only while idle.
// Timing: one request at a time. The feedback product runs bit-serially over
// the 15 pole bits, then the gain over its 4 bits; the result is then loaded
// into the output register and a new request can be taken. The output register
// lets the next request be accepted while a result still waits; if it is still
// occupied when the next result finishes, that result holds in the datapath
// until out_ready frees it.
// Reset (rst_n, asynchronous): filter history and peak cleared, gain 6,
// pole 32604, no result pending.
module audio_dc_block_gain_peak_unit
    import adcbgp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_ready,
    input  in_item_t            in_data,
    output logic                out_valid,
    input  logic                out_ready,
    output out_item_t           out_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [CfgIdxW-1:0]  cfg_index,
    input  logic [PoleW-1:0]    cfg_data
);

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_FB   = 4'b0010,
        S_GAIN = 4'b0100,
        S_OUT  = 4'b1000
    } state_t;

    state_t                 state_reg, state_next;
    logic [GainW-1:0]       gain_reg;
    logic [PoleW-1:0]       pole_reg;
    logic signed [PcmW-1:0] x_reg;
    logic                   last_reg;
    logic signed [PcmW-1:0] prev_in_reg;
    logic signed [RawW-1:0] prev_out_reg;
    logic [PcmW-1:0]        peak_reg;
    logic                   out_valid_reg;
    out_item_t              out_reg;

    mul_req_t               fb_req, gn_req;
    mul_rsp_t               fb_rsp, gn_rsp;
    logic [RawW-1:0]        fb;
    logic signed [RawW-1:0] sum;
    logic signed [PcmW-1:0] pcm;
    logic [PcmW-1:0]        mag;
    logic [PcmW-1:0]        peak_new;
    logic                   in_fire, cfg_fire, load_out;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign load_out  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign sum = RawW'(x_reg) - RawW'(prev_in_reg) + $signed(fb);
    assign peak_new = (mag > peak_reg) ? mag : peak_reg;

    assign fb_req.start = in_fire;
    assign gn_req.start = (state_reg == S_FB) && fb_rsp.done;

    adcbgp_pole_mul u_pole_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (fb_req),
        .y     (prev_out_reg),
        .pole  (pole_reg),
        .rsp   (fb_rsp),
        .fb    (fb)
    );

    adcbgp_gain_sat u_gain_sat (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (gn_req),
        .sum   (sum),
        .gain  (gain_reg),
        .rsp   (gn_rsp),
        .pcm   (pcm),
        .mag   (mag)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_fire)
                    state_next = S_FB;
            end
            S_FB:
            begin
                if (fb_rsp.done)
                    state_next = S_GAIN;
            end
            S_GAIN:
            begin
                if (gn_rsp.done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (load_out)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            gain_reg      <= GainReset;
            pole_reg      <= PoleReset;
            prev_in_reg   <= '0;
            prev_out_reg  <= '0;
            peak_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_fire)
            begin
                if (cfg_index == CFG_GAIN_FACTOR)
                    gain_reg <= cfg_data[GainW-1:0];
                else if (cfg_index == CFG_POLE_COEFF)
                    pole_reg <= cfg_data;
            end
            if (gn_req.start)
            begin
                prev_in_reg  <= x_reg;
                prev_out_reg <= sum;
            end
            if (load_out)
            begin
                peak_reg      <= last_reg ? '0 : peak_new;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            x_reg    <= in_data.raw_word[RawW-1 -: PcmW];
            last_reg <= in_data.last_in_block;
        end
        if (load_out)
        begin
            out_reg.pcm_sample <= pcm;
            out_reg.block_peak <= last_reg ? peak_new : '0;
            out_reg.block_end  <= last_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

endmodule

@@ hdl/adcbgp_checker.sv @@
`timescale 1ns / 1ps

module adcbgp_checker
    import adcbgp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic                in_ready,
    input  logic                out_valid,
    input  logic                out_ready,
    input  out_item_t           out_data
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_data))
        else $error("stalled result changed");

    // one request in flight: busy right after acceptance
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request accepted while busy");

    a_peak_only_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.block_end |-> out_data.block_peak == '0)
        else $error("peak reported outside block end");

    a_peak_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.block_end |-> out_data.block_peak <= 16'h8000)
        else $error("peak beyond 32768");

    a_peak_covers_min: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.block_end && out_data.pcm_sample == PcmMin
        |-> out_data.block_peak == 16'h8000)
        else $error("peak misses full-scale negative sample");

endmodule

bind audio_dc_block_gain_peak_unit adcbgp_checker u_adcbgp_checker (.*);
